// ===== src/ll1_table_parse_engine_assert.svh =====
// Assertion helpers for the parse engine.
`ifndef LL1_TABLE_PARSE_ENGINE_ASSERT_SVH
`define LL1_TABLE_PARSE_ENGINE_ASSERT_SVH

// Same-cycle implication under reset.
`define LL1_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under reset.
`define LL1_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ll1tpe_pkg.sv =====
`default_nettype none
package ll1tpe_pkg;

    localparam int MAX_TERMINALS_DEF    = 64;
    localparam int MAX_NONTERMINALS_DEF = 64;
    localparam int MAX_RULES_DEF        = 128;
    localparam int STORE_DEPTH_DEF      = 1024;
    localparam int STACK_DEPTH_DEF      = 64;

    localparam logic [2:0] KIND_LOAD_TABLE = 3'd0;
    localparam logic [2:0] KIND_LOAD_RULE  = 3'd1;
    localparam logic [2:0] KIND_LOAD_SYM   = 3'd2;
    localparam logic [2:0] KIND_START      = 3'd3;
    localparam logic [2:0] KIND_TOKEN      = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ACCEPT   = 3'd1;
    localparam logic [2:0] ST_SYNTAX   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic CFG_TERM_COUNT = 1'b0;
    localparam logic CFG_START_RULE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP_RD,
        S_TOP,
        S_TBL,
        S_RS,
        S_SYM,
        S_WALK_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] nonterm_index;
        logic [5:0] term_index;
        logic [6:0] rule_number;
        logic [9:0] store_address;
        logic [6:0] symbol_value;
        logic [6:0] token;
        logic       token_rejected;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] expected_symbol;
        logic [6:0] actual_token;
        logic [6:0] stack_level;
    } out_item_t;

endpackage
`default_nettype wire

// ===== src/ll1_table_parse_engine.sv =====
// LL(1) table-driven parse engine; one item in flight, results in order.
// Loads, ignored items and a token on an empty stack go straight to a result; a start
// reads its rule and pushes its symbols; a token pops a matching terminal or expands
// the top nonterminal through the table. Runaway parses stop after STACK_DEPTH*MAX_RULES
// expansions. Items are taken one at a time; a stalled result holds the next item off.
// Reset (synchronous, active low) clears control registers; stores stay unwritten.
`default_nettype none
`include "ll1_table_parse_engine_assert.svh"
module ll1_table_parse_engine #(
    parameter int MAX_TERMINALS    = ll1tpe_pkg::MAX_TERMINALS_DEF,
    parameter int MAX_NONTERMINALS = ll1tpe_pkg::MAX_NONTERMINALS_DEF,
    parameter int MAX_RULES        = ll1tpe_pkg::MAX_RULES_DEF,
    parameter int STORE_DEPTH      = ll1tpe_pkg::STORE_DEPTH_DEF,
    parameter int STACK_DEPTH      = ll1tpe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ll1tpe_pkg::in_item_t s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ll1tpe_pkg::out_item_t     m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_addr,
    input  wire logic [6:0]           cfg_wr_data
);
    // address widths of the four stores
    localparam int TBL_DEPTH = MAX_NONTERMINALS * MAX_TERMINALS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int RS_AW     = $clog2(MAX_RULES);
    localparam int ST_AW     = $clog2(STORE_DEPTH);
    localparam int SP_AW     = $clog2(STACK_DEPTH);
    localparam int MAX_EXP   = STACK_DEPTH * MAX_RULES;
    localparam int CNT_W     = $clog2(MAX_EXP + 2);

    localparam logic [6:0]       MAX_NT_L  = 7'(MAX_NONTERMINALS);
    localparam logic [6:0]       MAX_T_L   = 7'(MAX_TERMINALS);
    localparam logic [7:0]       MAX_R_L   = 8'(MAX_RULES);
    localparam logic [10:0]      ST_DEP_L  = 11'(STORE_DEPTH);
    localparam logic [6:0]       SK_DEP_L  = 7'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] MAX_EXP_L = CNT_W'(MAX_EXP);

    // configuration
    logic [5:0] tc_reg;
    logic [6:0] start_rule_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg         <= 6'd63;
            start_rule_reg <= 7'd1;
        end else if (cfg_wr_en) begin
            if (cfg_addr == ll1tpe_pkg::CFG_TERM_COUNT) begin
                tc_reg <= cfg_wr_data[5:0];
            end else begin
                start_rule_reg <= cfg_wr_data;
            end
        end
    end

    // control and working registers
    ll1tpe_pkg::state_t state_reg, state_next;
    logic [6:0]         sp_reg, sp_next;
    logic               active_reg, active_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [10:0]        walk_reg, walk_next;
    logic [6:0]         top_reg, top_next;
    logic               is_start_reg, is_start_next;
    logic [6:0]         tok_reg, tok_next;
    logic               rej_reg, rej_next;
    logic [2:0]         res_st_reg, res_st_next;
    logic [6:0]         res_exp_reg, res_exp_next;
    logic [6:0]         res_act_reg, res_act_next;
    logic               m_valid_reg;
    ll1tpe_pkg::out_item_t m_data_reg;

    // memory ports
    logic              tbl_we, rs_we, sym_we, stk_we;
    logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
    logic [RS_AW-1:0]  rs_waddr, rs_raddr;
    logic [ST_AW-1:0]  sym_waddr, sym_raddr;
    logic [SP_AW-1:0]  stk_waddr, stk_raddr;
    logic [6:0]        tbl_q, sym_q, stk_q;
    logic [9:0]        rs_q;

    // decision terms
    logic       acc, out_free;
    logic       top_term, lk_ok, tbl_zero, r_big, rs_beyond, sym_zero, full, walk_last;
    logic [6:0] row, col;
    logic [CNT_W-1:0] cnt_inc;
    logic [10:0] walk_inc;
    logic [6:0] sp_dec;

    assign acc       = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign top_term  = stk_q <= {1'b0, tc_reg};
    assign row       = stk_q - {1'b0, tc_reg} - 7'd1;
    assign col       = tok_reg - 7'd1;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign lk_ok     = (tok_reg != 7'd0) && (row < MAX_NT_L) && (col < MAX_T_L)
                       && (cnt_inc <= MAX_EXP_L);
    assign tbl_zero  = tbl_q == 7'd0;
    assign r_big     = {1'b0, tbl_q} >= MAX_R_L;
    assign rs_beyond = {1'b0, rs_q} >= ST_DEP_L;
    assign sym_zero  = sym_q == 7'd0;
    assign full      = sp_reg >= SK_DEP_L;
    assign walk_inc  = walk_reg + 11'd1;
    assign walk_last = walk_inc >= ST_DEP_L;
    assign sp_dec    = sp_reg - 7'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ll1tpe_pkg::S_IDLE: begin
                if (acc) begin
                    if (s_data.kind == ll1tpe_pkg::KIND_START) begin
                        state_next = ({1'b0, start_rule_reg} >= MAX_R_L)
                                     ? ll1tpe_pkg::S_WALK_END : ll1tpe_pkg::S_RS;
                    end else if (s_data.kind == ll1tpe_pkg::KIND_TOKEN && active_reg
                                 && sp_reg != 7'd0) begin
                        state_next = ll1tpe_pkg::S_TOP_RD;
                    end else begin
                        state_next = ll1tpe_pkg::S_DONE;
                    end
                end
            end
            ll1tpe_pkg::S_TOP_RD: state_next = ll1tpe_pkg::S_TOP;
            ll1tpe_pkg::S_TOP: begin
                if (rej_reg || top_term || !lk_ok) begin
                    state_next = ll1tpe_pkg::S_DONE;
                end else begin
                    state_next = ll1tpe_pkg::S_TBL;
                end
            end
            ll1tpe_pkg::S_TBL: begin
                priority if (tbl_zero) state_next = ll1tpe_pkg::S_DONE;
                else if (r_big)        state_next = ll1tpe_pkg::S_WALK_END;
                else                   state_next = ll1tpe_pkg::S_RS;
            end
            ll1tpe_pkg::S_RS: begin
                state_next = rs_beyond ? ll1tpe_pkg::S_WALK_END : ll1tpe_pkg::S_SYM;
            end
            ll1tpe_pkg::S_SYM: begin
                priority if (sym_zero) state_next = ll1tpe_pkg::S_WALK_END;
                else if (full)         state_next = ll1tpe_pkg::S_DONE;
                else if (walk_last)    state_next = ll1tpe_pkg::S_WALK_END;
                else                   state_next = ll1tpe_pkg::S_SYM;
            end
            ll1tpe_pkg::S_WALK_END: begin
                if (is_start_reg || sp_reg == 7'd0) begin
                    state_next = ll1tpe_pkg::S_DONE;
                end else begin
                    state_next = ll1tpe_pkg::S_TOP_RD;
                end
            end
            ll1tpe_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = ll1tpe_pkg::S_IDLE;
                end
            end
            default: state_next = ll1tpe_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        sp_next       = sp_reg;
        active_next   = active_reg;
        cnt_next      = cnt_reg;
        walk_next     = walk_reg;
        top_next      = top_reg;
        is_start_next = is_start_reg;
        tok_next      = tok_reg;
        rej_next      = rej_reg;
        res_st_next   = res_st_reg;
        res_exp_next  = res_exp_reg;
        res_act_next  = res_act_reg;

        tbl_we    = 1'b0;
        rs_we     = 1'b0;
        sym_we    = 1'b0;
        stk_we    = 1'b0;
        tbl_waddr = TBL_AW'(32'(s_data.nonterm_index) * MAX_TERMINALS
                            + 32'(s_data.term_index));
        rs_waddr  = s_data.rule_number[RS_AW-1:0];
        sym_waddr = s_data.store_address[ST_AW-1:0];
        stk_waddr = sp_reg[SP_AW-1:0];
        tbl_raddr = TBL_AW'(32'(row) * MAX_TERMINALS + 32'(col));
        rs_raddr  = (state_reg == ll1tpe_pkg::S_IDLE) ? start_rule_reg[RS_AW-1:0]
                                                      : tbl_q[RS_AW-1:0];
        sym_raddr = (state_reg == ll1tpe_pkg::S_RS) ? rs_q[ST_AW-1:0]
                                                    : walk_inc[ST_AW-1:0];
        stk_raddr = sp_dec[SP_AW-1:0];

        unique case (state_reg)
            ll1tpe_pkg::S_IDLE: begin
                if (acc) begin
                    res_st_next   = ll1tpe_pkg::ST_OK;
                    res_exp_next  = 7'd0;
                    res_act_next  = 7'd0;
                    cnt_next      = '0;
                    tok_next      = s_data.token;
                    rej_next      = s_data.token_rejected;
                    is_start_next = s_data.kind == ll1tpe_pkg::KIND_START;
                    unique case (s_data.kind)
                        ll1tpe_pkg::KIND_LOAD_TABLE: begin
                            tbl_we = ({1'b0, s_data.nonterm_index} < MAX_NT_L)
                                     && ({1'b0, s_data.term_index} < MAX_T_L);
                        end
                        ll1tpe_pkg::KIND_LOAD_RULE: begin
                            rs_we = {1'b0, s_data.rule_number} < MAX_R_L;
                        end
                        ll1tpe_pkg::KIND_LOAD_SYM: begin
                            sym_we = {1'b0, s_data.store_address} < ST_DEP_L;
                        end
                        ll1tpe_pkg::KIND_START: begin
                            sp_next     = 7'd0;
                            active_next = 1'b1;
                        end
                        ll1tpe_pkg::KIND_TOKEN: begin
                            if (!active_reg) begin
                                res_st_next = ll1tpe_pkg::ST_IGNORED;
                            end else if (sp_reg == 7'd0) begin
                                res_st_next = ll1tpe_pkg::ST_ACCEPT;
                                active_next = 1'b0;
                            end
                        end
                        default: res_st_next = ll1tpe_pkg::ST_IGNORED;
                    endcase
                end
            end
            ll1tpe_pkg::S_TOP: begin
                top_next = stk_q;
                if (!rej_reg && top_term && stk_q == tok_reg) begin
                    // terminal match: pop; an empty stack accepts
                    sp_next = sp_dec;
                    if (sp_dec == 7'd0) begin
                        res_st_next = ll1tpe_pkg::ST_ACCEPT;
                        active_next = 1'b0;
                    end
                end else if (rej_reg || top_term || !lk_ok) begin
                    res_st_next  = ll1tpe_pkg::ST_SYNTAX;
                    res_exp_next = stk_q;
                    res_act_next = tok_reg;
                    active_next  = 1'b0;
                end
                if (!rej_reg && !top_term) begin
                    cnt_next = cnt_inc;
                end
            end
            ll1tpe_pkg::S_TBL: begin
                if (tbl_zero) begin
                    res_st_next  = ll1tpe_pkg::ST_SYNTAX;
                    res_exp_next = top_reg;
                    res_act_next = tok_reg;
                    active_next  = 1'b0;
                end else begin
                    sp_next = sp_dec;
                end
            end
            ll1tpe_pkg::S_RS: begin
                walk_next = {1'b0, rs_q};
            end
            ll1tpe_pkg::S_SYM: begin
                if (!sym_zero) begin
                    if (full) begin
                        res_st_next = ll1tpe_pkg::ST_OVERFLOW;
                        active_next = 1'b0;
                    end else begin
                        stk_we    = 1'b1;
                        sp_next   = sp_reg + 7'd1;
                        walk_next = walk_inc;
                    end
                end
            end
            ll1tpe_pkg::S_WALK_END: begin
                if (sp_reg == 7'd0) begin
                    res_st_next = ll1tpe_pkg::ST_ACCEPT;
                    active_next = 1'b0;
                end
            end
            ll1tpe_pkg::S_TOP_RD, ll1tpe_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ll1tpe_pkg::S_IDLE;
            sp_reg      <= 7'd0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            active_reg <= active_next;
            if (state_reg == ll1tpe_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        walk_reg     <= walk_next;
        top_reg      <= top_next;
        is_start_reg <= is_start_next;
        tok_reg      <= tok_next;
        rej_reg      <= rej_next;
        res_st_reg   <= res_st_next;
        res_exp_reg  <= res_exp_next;
        res_act_reg  <= res_act_next;
        if (state_reg == ll1tpe_pkg::S_DONE && out_free) begin
            m_data_reg.status          <= res_st_reg;
            m_data_reg.expected_symbol <= res_exp_reg;
            m_data_reg.actual_token    <= res_act_reg;
            m_data_reg.stack_level     <= sp_reg;
        end
    end

    assign s_ready = state_reg == ll1tpe_pkg::S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stores: parse table, rule starts, symbol store, parse stack
    ll1tpe_ram #(.DEPTH(TBL_DEPTH), .WIDTH(7), .AW(TBL_AW)) u_tbl (
        .aclk(aclk), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(s_data.rule_number),
        .rd_addr(tbl_raddr), .rd_data(tbl_q)
    );
    ll1tpe_ram #(.DEPTH(MAX_RULES), .WIDTH(10), .AW(RS_AW)) u_rs (
        .aclk(aclk), .wr_en(rs_we), .wr_addr(rs_waddr), .wr_data(s_data.store_address),
        .rd_addr(rs_raddr), .rd_data(rs_q)
    );
    ll1tpe_ram #(.DEPTH(STORE_DEPTH), .WIDTH(7), .AW(ST_AW)) u_sym (
        .aclk(aclk), .wr_en(sym_we), .wr_addr(sym_waddr), .wr_data(s_data.symbol_value),
        .rd_addr(sym_raddr), .rd_data(sym_q)
    );
    ll1tpe_ram #(.DEPTH(STACK_DEPTH), .WIDTH(7), .AW(SP_AW)) u_stk (
        .aclk(aclk), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(sym_q),
        .rd_addr(stk_raddr), .rd_data(stk_q)
    );

    // every accepted item leaves idle and heads for a result
    `LL1_ASSERT_NEXT(a_item_busy, aclk, aresetn, acc, state_reg != ll1tpe_pkg::S_IDLE)
    // a finished item with a free output slot shows its result next cycle
    `LL1_ASSERT_NEXT(a_done_out, aclk, aresetn,
        state_reg == ll1tpe_pkg::S_DONE && out_free, m_valid_reg)
    // the stack never grows beyond its depth
    `LL1_ASSERT_NOW(a_sp_bound, aclk, aresetn, 1'b1, sp_reg <= SK_DEP_L)
    // a parse ends only on its way to a result
    `LL1_ASSERT_NOW(a_end_done, aclk, aresetn, $fell(active_reg),
        state_reg == ll1tpe_pkg::S_DONE)
endmodule
`default_nettype wire

// ===== src/ll1tpe_ram.sv =====
`default_nettype none
module ll1tpe_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire
